// File: hdl/pwrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrs_pkg
// Shared types, constants and helper functions of the write request splitter.
// ----------------------------------------------------------------------------
package pwrs_pkg;

  localparam int unsigned PACKET_BYTES      = 128;
  localparam int unsigned MAX_REQUEST_BYTES = 4096;
  localparam int unsigned ADDRESS_BITS      = 48;

  // fixed field widths of the item channels
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BE_W     = 4;
  localparam int unsigned OFFSET_W = 12;

  localparam logic [BE_W-1:0] BE_ALL = 4'hf;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // one packet descriptor
  typedef struct packed {
    logic [ADDR_W-1:0]   packet_address;
    logic [LEN_W-1:0]    dword_length;
    logic [BE_W-1:0]     first_enable;
    logic [BE_W-1:0]     last_enable;
    logic                wide_header;
    logic [OFFSET_W-1:0] payload_offset;
    logic                final_packet;
  } pkt_t;

  // enables of the n lowest bytes of a dword, n in 1..4
  function automatic logic [BE_W-1:0] count_enable(input logic [2:0] n);
    logic [BE_W-1:0] be;
    unique case (n)
      3'd1:    be = 4'h1;
      3'd2:    be = 4'h3;
      3'd3:    be = 4'h7;
      3'd0:    be = 4'h0;
      default: be = BE_ALL;
    endcase
    return be;
  endfunction

endpackage

// File: hdl/pwrs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrs_req_if
// Request channel: one memory-write request per item.
// ----------------------------------------------------------------------------
interface pwrs_req_if;
  logic                          valid;
  logic                          ready;
  logic [pwrs_pkg::ADDR_W-1:0]   start_address;
  logic [pwrs_pkg::COUNT_W-1:0]  byte_count;

  modport source (output valid, output start_address, output byte_count, input ready);
  modport sink   (input valid, input start_address, input byte_count, output ready);
endinterface

// File: hdl/pwrs_pkt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrs_pkt_if
// Descriptor channel: one memory-write packet descriptor per item.
// ----------------------------------------------------------------------------
interface pwrs_pkt_if;
  logic                           valid;
  logic                           ready;
  logic [pwrs_pkg::ADDR_W-1:0]    packet_address;
  logic [pwrs_pkg::LEN_W-1:0]     dword_length;
  logic [pwrs_pkg::BE_W-1:0]      first_enable;
  logic [pwrs_pkg::BE_W-1:0]      last_enable;
  logic                           wide_header;
  logic [pwrs_pkg::OFFSET_W-1:0]  payload_offset;
  logic                           final_packet;

  modport source (
    output valid, output packet_address, output dword_length, output first_enable,
    output last_enable, output wide_header, output payload_offset,
    output final_packet, input ready
  );
  modport sink (
    input valid, input packet_address, input dword_length, input first_enable,
    input last_enable, input wide_header, input payload_offset,
    input final_packet, output ready
  );
endinterface

// File: hdl/pwrs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrs_step
// Step unit: cuts the next packet off the remaining request.
// ----------------------------------------------------------------------------
module pwrs_step #(
  parameter int unsigned ADDRESS_BITS = pwrs_pkg::ADDRESS_BITS,
  parameter int unsigned PACKET_BYTES = pwrs_pkg::PACKET_BYTES,
  parameter int unsigned CNT_W        = 13,
  parameter int unsigned TAKE_W       = 13
) (
  input  logic [ADDRESS_BITS-1:0]       addr_i,
  input  logic [CNT_W-1:0]              cnt_i,
  input  logic [pwrs_pkg::OFFSET_W-1:0] off_i,
  output logic [TAKE_W-1:0]             take_o,
  output pwrs_pkg::pkt_t                pkt_o
);

  localparam int unsigned PBW = $clog2(PACKET_BYTES);

  logic [TAKE_W-1:0]       cnt_w;
  logic [TAKE_W-1:0]       room;
  logic [TAKE_W-1:0]       take;
  logic [TAKE_W-1:0]       len_w;
  logic [1:0]              sh;
  logic [pwrs_pkg::BE_W-1:0] be;
  logic [7:0]              be_sh;
  logic [ADDRESS_BITS-1:0] paddr;

  always_comb begin
    cnt_w = TAKE_W'(cnt_i);
    sh    = addr_i[1:0];
    pkt_o = '0;
    be_sh = '0;
    len_w = '0;
    if (sh != 2'd0) begin
      // unaligned head: one dword up to the next dword boundary
      be    = (cnt_w < TAKE_W'(3)) ? pwrs_pkg::count_enable(cnt_w[2:0])
                                   : pwrs_pkg::BE_ALL;
      be_sh = {4'h0, be} << sh;
      room  = TAKE_W'(3'd4 - {1'b0, sh});
      take  = (cnt_w < room) ? cnt_w : room;
      paddr = {addr_i[ADDRESS_BITS-1:2], 2'b00};
      pkt_o.dword_length = pwrs_pkg::LEN_W'(1);
      pkt_o.first_enable = be_sh[3:0];
      pkt_o.last_enable  = '0;
    end else begin
      room  = TAKE_W'(PACKET_BYTES) - TAKE_W'(addr_i[PBW-1:0]);
      take  = (room < cnt_w) ? room : cnt_w;
      be    = (take[1:0] != 2'd0) ? pwrs_pkg::count_enable({1'b0, take[1:0]})
                                  : pwrs_pkg::BE_ALL;
      paddr = addr_i;
      if (take <= TAKE_W'(4)) begin
        pkt_o.dword_length = pwrs_pkg::LEN_W'(1);
        pkt_o.first_enable = be;
        pkt_o.last_enable  = '0;
      end else begin
        len_w = (take + TAKE_W'(3)) >> 2;
        pkt_o.dword_length = len_w[pwrs_pkg::LEN_W-1:0];
        pkt_o.first_enable = pwrs_pkg::BE_ALL;
        pkt_o.last_enable  = be;
      end
    end
    pkt_o.packet_address = pwrs_pkg::ADDR_W'(paddr);
    pkt_o.wide_header    = |paddr[ADDRESS_BITS-1:32];
    pkt_o.payload_offset = off_i;
    pkt_o.final_packet   = (take == cnt_w);
    take_o = take;
  end

endmodule

// File: hdl/pcie_write_request_splitter.sv
`timescale 1ns / 1ps
// First descriptor: cut from the request registers after the request is accepted,
//   and loaded into the descriptor register provided that register is free.
// Throughput: one descriptor per cycle while the sink is ready; a request of N
//   packets (N <= 34 at the defaults) holds off requests until its last is cut.
//   The single step unit sets the rate, one packet per cycle while it can load.
// Reset (rst_ni low, asynchronous): sequencer idle, descriptor register empty.
// ----------------------------------------------------------------------------
// pcie_write_request_splitter
// Splits a memory-write request into PCIe memory-write packet descriptors.
// ----------------------------------------------------------------------------
module pcie_write_request_splitter #(
  // PACKET_BYTES must be a power of two
  parameter int unsigned PACKET_BYTES      = pwrs_pkg::PACKET_BYTES,
  parameter int unsigned MAX_REQUEST_BYTES = pwrs_pkg::MAX_REQUEST_BYTES,
  parameter int unsigned ADDRESS_BITS      = pwrs_pkg::ADDRESS_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  pwrs_req_if.sink   req_i,
  pwrs_pkt_if.source pkt_o
);

  // remaining byte count and per-step take width
  localparam int unsigned CNT_W  = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int unsigned PB_W   = $clog2(PACKET_BYTES) + 1;
  localparam int unsigned TAKE_W = (CNT_W > PB_W) ? CNT_W : PB_W;

  pwrs_pkg::state_e state_q, state_d;

  logic [ADDRESS_BITS-1:0]       addr_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [pwrs_pkg::OFFSET_W-1:0] off_q;
  pwrs_pkg::pkt_t                out_q;
  logic                          out_vld_q;

  logic                          accept;
  logic                          load;
  logic [CNT_W-1:0]              cnt_sat;
  logic [TAKE_W-1:0]             take;
  pwrs_pkg::pkt_t                step_pkt;

  // Byte counts above the maximum are clamped.
  assign cnt_sat = (32'(req_i.byte_count) > 32'(MAX_REQUEST_BYTES))
                 ? CNT_W'(MAX_REQUEST_BYTES) : CNT_W'(req_i.byte_count);

  assign accept = req_i.valid && req_i.ready;

  // The step unit sees the live request state; while running, a packet is cut
  // whenever the descriptor register is free or being drained this cycle.
  pwrs_step #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .PACKET_BYTES (PACKET_BYTES),
    .CNT_W        (CNT_W),
    .TAKE_W       (TAKE_W)
  ) u_step (
    .addr_i (addr_q),
    .cnt_i  (cnt_q),
    .off_i  (off_q),
    .take_o (take),
    .pkt_o  (step_pkt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwrs_pkg::ST_IDLE: begin
        if (accept && (cnt_sat != '0)) state_d = pwrs_pkg::ST_RUN;
      end
      pwrs_pkg::ST_RUN: begin
        if (load && step_pkt.final_packet) state_d = pwrs_pkg::ST_IDLE;
      end
      default: state_d = pwrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      pwrs_pkg::ST_IDLE: req_i.ready = 1'b1;
      pwrs_pkg::ST_RUN:  load = !out_vld_q || pkt_o.ready;
      default: begin
        req_i.ready = 1'b0;
        load        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwrs_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (pkt_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // request state and descriptor register (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= ADDRESS_BITS'(req_i.start_address);
      cnt_q  <= cnt_sat;
      off_q  <= '0;
    end else if (load) begin
      addr_q <= addr_q + ADDRESS_BITS'(take);
      cnt_q  <= cnt_q - CNT_W'(take);
      off_q  <= off_q + pwrs_pkg::OFFSET_W'(take);
    end
    if (load) out_q <= step_pkt;
  end

  assign pkt_o.valid          = out_vld_q;
  assign pkt_o.packet_address = out_q.packet_address;
  assign pkt_o.dword_length   = out_q.dword_length;
  assign pkt_o.first_enable   = out_q.first_enable;
  assign pkt_o.last_enable    = out_q.last_enable;
  assign pkt_o.wide_header    = out_q.wide_header;
  assign pkt_o.payload_offset = out_q.payload_offset;
  assign pkt_o.final_packet   = out_q.final_packet;

  // A descriptor only appears after a packet was cut while running.
  a_vld_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == pwrs_pkg::ST_RUN))
    else $error("descriptor without running request");

  // While running there are bytes left and each step takes some.
  a_run_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwrs_pkg::ST_RUN) |-> (cnt_q != '0) && (take != '0))
    else $error("running with nothing to take");

  // Only the first packet of a request can start off a dword boundary.
  a_head_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwrs_pkg::ST_RUN) && (addr_q[1:0] != 2'd0) |-> (off_q == '0))
    else $error("unaligned packet after head");

  // A cut packet is never dropped: the register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_vld_q || pkt_o.ready))
    else $error("descriptor overwritten");

endmodule

// File: tb/pwrs_descriptor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrs_descriptor_checker
// Watches the request and descriptor channels of the write request splitter,
// works out the descriptors every accepted request must produce and compares
// each accepted descriptor, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module pwrs_descriptor_checker
  import pwrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pwrs_req_if         req_i,
  pwrs_pkt_if         pkt_i,
  output int unsigned fail_count_o,
  output int unsigned pending_count_o
);

  localparam int unsigned MAX_LINES = 50;

  pkt_t expected_pkts[$];

  task automatic report(input string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_LINES) begin
      $display("%0t ns: descriptor check: %s", $time, msg);
    end
  endtask

  // enables of the n lowest bytes, n in 1..4
  function automatic logic [BE_W-1:0] low_enables(input int unsigned n);
    return BE_ALL >> (4 - n);
  endfunction

  function automatic pkt_t make_pkt(input logic [ADDR_W-1:0] addr, input int unsigned dwords,
                                    input logic [BE_W-1:0] first, input logic [BE_W-1:0] last,
                                    input int unsigned off, input logic fin);
    pkt_t p;
    p.packet_address = addr;
    p.dword_length   = LEN_W'(dwords);
    p.first_enable   = first;
    p.last_enable    = last;
    p.wide_header    = |addr[ADDR_W-1:32];
    p.payload_offset = OFFSET_W'(off);
    p.final_packet   = fin;
    return p;
  endfunction

  // queue the descriptors that one request turns into
  task automatic split_request(input logic [ADDR_W-1:0] start, input logic [COUNT_W-1:0] nbytes);
    logic [ADDR_W-1:0] addr;
    logic [BE_W-1:0]   be;
    int unsigned       left;
    int unsigned       off;
    int unsigned       take;
    int unsigned       room;
    addr = start;
    left = nbytes;
    off  = 0;
    if (left > MAX_REQUEST_BYTES) left = MAX_REQUEST_BYTES;
    // unaligned head: one dword, enables shifted and cut to 4 bits
    if (left != 0 && addr[1:0] != 2'd0) begin
      take = 4 - addr[1:0];
      be   = (left < 3) ? low_enables(left) : BE_ALL;
      be   = be << addr[1:0];
      if (left < take) take = left;
      expected_pkts.push_back(make_pkt({addr[ADDR_W-1:2], 2'b00}, 1, be, '0, off,
                                       left == take));
      left -= take;
      off  += take;
      addr += ADDR_W'(take);
    end
    while (left != 0) begin
      room = PACKET_BYTES - int'(addr % PACKET_BYTES);
      take = (room < left) ? room : left;
      be   = (take % 4 != 0) ? low_enables(take % 4) : BE_ALL;
      if (take <= 4) begin
        expected_pkts.push_back(make_pkt(addr, 1, be, '0, off, take == left));
      end else begin
        expected_pkts.push_back(make_pkt(addr, (take + 3) / 4, BE_ALL, be, off, take == left));
      end
      left -= take;
      off  += take;
      addr += ADDR_W'(take);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pkt_t got;
    pkt_t want;
    if (!rst_ni) begin
      expected_pkts.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      // descriptor side first: a request taken at this edge cannot answer yet
      if (pkt_i.valid && pkt_i.ready) begin
        got.packet_address = pkt_i.packet_address;
        got.dword_length   = pkt_i.dword_length;
        got.first_enable   = pkt_i.first_enable;
        got.last_enable    = pkt_i.last_enable;
        got.wide_header    = pkt_i.wide_header;
        got.payload_offset = pkt_i.payload_offset;
        got.final_packet   = pkt_i.final_packet;
        if (expected_pkts.size() == 0) begin
          report($sformatf("unexpected descriptor at 0x%0h", got.packet_address));
        end else begin
          want = expected_pkts.pop_front();
          check_field("packet_address", 64'(got.packet_address), 64'(want.packet_address));
          check_field("dword_length",   64'(got.dword_length),   64'(want.dword_length));
          check_field("first_enable",   64'(got.first_enable),   64'(want.first_enable));
          check_field("last_enable",    64'(got.last_enable),    64'(want.last_enable));
          check_field("wide_header",    64'(got.wide_header),    64'(want.wide_header));
          check_field("payload_offset", 64'(got.payload_offset), 64'(want.payload_offset));
          check_field("final_packet",   64'(got.final_packet),   64'(want.final_packet));
        end
      end
      if (req_i.valid && req_i.ready) begin
        split_request(req_i.start_address, req_i.byte_count);
      end
      pending_count_o <= expected_pkts.size();
    end
  end

endmodule

// File: tb/tb_pcie_write_request_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcie_write_request_splitter
// Drives memory-write requests into the splitter and gives the verdict; the
// descriptor checker beside the block predicts and compares every packet.
// ----------------------------------------------------------------------------
module tb_pcie_write_request_splitter;
  import pwrs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned HOLD_CYCLES  = 400;  // long descriptor-side back-pressure
  localparam int unsigned TAIL_CYCLES  = 20;   // quiet time after the last descriptor

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;

  // idle/stall odds in percent, and the remaining cycles of a forced hold-off
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  pwrs_req_if req_ch ();
  pwrs_pkt_if pkt_ch ();

  pcie_write_request_splitter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .pkt_o  (pkt_ch)
  );

  pwrs_descriptor_checker descriptor_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_ch),
    .pkt_i           (pkt_ch),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit: far beyond the slowest correct run (372 requests of up to
  // 34 descriptors each under heavy stalls).
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Descriptor sink: random stalls, or a counted hold-off when one is armed.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pkt_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        pkt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request; called at a falling edge, returns at the falling edge
  // after the item was taken, with valid still high.
  task automatic offer_write(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] nbytes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.start_address <= addr;
    req_ch.byte_count    <= nbytes;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted descriptor has come out.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Random request: address classes that hit the 4 GiB line and the 48-bit
  // wrap, counts mostly short so that the run stays quick.
  task automatic offer_random();
    logic [63:0]        r;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] nbytes;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: addr = r[ADDR_W-1:0];
      1: addr = {16'h0, r[31:0]};
      2: addr = 48'h1_0000_0000 - ADDR_W'($urandom_range(0, 512));
      3: addr = 48'hffff_ffff_ffff - ADDR_W'($urandom_range(0, 600));
      4: addr = ADDR_W'($urandom_range(0, 1023));
      default: addr = {r[47:7], 7'h7f - 7'($urandom_range(0, 7))};
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: nbytes = COUNT_W'($urandom_range(0, 300));
      5, 6:          nbytes = COUNT_W'($urandom_range(0, 8191));
      7:             nbytes = COUNT_W'(MAX_REQUEST_BYTES);
      8:             nbytes = COUNT_W'($urandom_range(1, 8));
      default:       nbytes = COUNT_W'($urandom_range(3990, 4100));
    endcase
    offer_write(addr, nbytes);
  endtask

  initial begin
    int unsigned ph;
    int unsigned i;
    rst_ni               = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.start_address = '0;
    req_ch.byte_count    = '0;
    pkt_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_left            = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed requests ---
    offer_write(48'h0, 13'd0);                      // zero count, nothing out
    offer_write(48'h0, 13'd1);
    offer_write(48'h0, 13'd4);                      // short aligned, one dword
    offer_write(48'h0, 13'd128);
    offer_write(48'h0, 13'd4096);                   // largest request
    offer_write(48'h3, 13'd4096);                   // unaligned max: 34 descriptors
    offer_write(48'h1, 13'd1);
    offer_write(48'h1, 13'd2);                      // head enables shifted
    offer_write(48'h2, 13'd2);
    offer_write(48'h3, 13'd2);                      // head enables cut to 4 bits
    offer_write(48'h1, 13'd3);
    offer_write(48'h2, 13'd5);
    offer_write(48'h3, 13'd1);
    offer_write(48'h100, 13'd8191);                 // oversized, saturates
    offer_write(48'h7f, 13'd4097);
    offer_write(48'hffff_ffff_fffe, 13'd10);        // wraps past the top
    offer_write(48'hffff_ffff_ff80, 13'd200);
    offer_write(48'hffff_ffff_ffff, 13'd4096);
    offer_write(48'h0000_ffff_fff0, 13'd40);        // crosses 4 GiB
    offer_write(48'h1_0000_0000, 13'd128);
    offer_write(48'h7c, 13'd7);                     // 4-byte packet then short tail
    offer_write(48'h40, 13'd66);
    offer_write(48'h5555_5555_5555, 13'd4095);
    offer_write(48'haaaa_aaaa_aaaa, 13'd2730);
    wait_drained();

    // --- random requests, four traffic phases ---
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 0) begin
        // starve the output for a while so the block backs up onto its input
        @(posedge clk_i);
        hold_left = HOLD_CYCLES;
        @(negedge clk_i);
      end
      for (i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        offer_random();
      end
      // sender pause until the block has emptied
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pwrs_pkg.sv
hdl/pwrs_req_if.sv
hdl/pwrs_pkt_if.sv
hdl/pwrs_step.sv
hdl/pcie_write_request_splitter.sv
tb/pwrs_descriptor_checker.sv
tb/tb_pcie_write_request_splitter.sv
